/* sv/bol_pkg.sv */
// Package for the bounded ordered list: beat types, codes and cell control structs.
`default_nettype none
package bol_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 16;
  localparam int IDX_W = 9;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    ACT_FRONT = 2'd0,
    ACT_BACK  = 2'd1,
    ACT_AT    = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_GATHER
  } fsm_t;

  localparam logic [IDX_W-1:0] NO_IDX = '1;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] value;
    logic [7:0]              position;
  } item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [4:0]              entry_count;
    logic signed [VAL_W-1:0] first_value;
    logic signed [VAL_W-1:0] last_value;
    logic signed [VAL_W-1:0] middle_value;
    logic                    middle_valid;
    logic signed [VAL_W-1:0] read_value;
  } result_t;

  typedef struct packed {
    logic             ins;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] cnt;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] mid_idx;
    logic [IDX_W-1:0] rd_idx;
  } cell_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] last;
    logic [VAL_W-1:0] mid;
    logic [VAL_W-1:0] rd;
  } cell_tap_t;

endpackage
`default_nettype wire

/* sv/bounded_ordered_list.sv */
// Bounded ordered list top level: control, count and a row of shifting cells.
// One item at a time: a beat is taken only in the idle state. The cell row shifts on
// insert when the item is accepted; the head, tail, middle and read taps are loaded
// in the gather state, which waits while the output holds a result not yet taken.
// Reset clears the count and control state; slot contents are undefined until written.
`default_nettype none
module bounded_ordered_list #(
  parameter int MAX_ENTRIES = bol_pkg::DEFAULT_MAX_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire bol_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output bol_pkg::result_t      result
);
  import bol_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  fsm_t            state, state_next;
  logic [CW-1:0]   count;
  logic [1:0]      status;
  logic [1:0]      status_next;
  logic            rd_ok;
  logic            rd_ok_next;
  logic [7:0]      rd_pos;
  logic            accept;
  logic            ins_ok;
  logic            load;
  logic [IDX_W-1:0] cnt_x;
  logic [IDX_W-1:0] pos_x;
  logic [IDX_W-1:0] ins_idx;
  cell_cmd_t       cmd;
  result_t         res_next;

  logic [VAL_W-1:0] cell_val [MAX_ENTRIES];
  cell_tap_t        cell_tap [MAX_ENTRIES];
  logic [VAL_W-1:0] last_or, mid_or, rd_or;

  assign cnt_x  = IDX_W'(count);
  assign pos_x  = IDX_W'(item.position);
  assign accept = item_valid && item_ready;

  always_comb begin
    status_next = ST_OK;
    rd_ok_next  = 1'b0;
    ins_ok      = 1'b0;
    ins_idx     = '0;
    unique case (action_t'(item.action))
      ACT_FRONT: ins_idx = '0;
      ACT_BACK:  ins_idx = cnt_x;
      ACT_AT:    ins_idx = pos_x - IDX_W'(1);
      ACT_READ:  ins_idx = '0;
      default:   ins_idx = '0;
    endcase
    if (action_t'(item.action) == ACT_READ) begin
      rd_ok_next = (pos_x != '0) && (pos_x <= cnt_x);
      status_next = rd_ok_next ? ST_OK : ST_BAD_POS;
    end else if (action_t'(item.action) == ACT_AT &&
                 (pos_x == '0 || pos_x > cnt_x + IDX_W'(1))) begin
      status_next = ST_BAD_POS;
    end else if (cnt_x >= IDX_W'(MAX_ENTRIES)) begin
      status_next = ST_FULL;
    end else begin
      ins_ok = 1'b1;
    end
  end

  always_comb begin
    cmd.ins      = accept && ins_ok;
    cmd.idx      = ins_idx;
    cmd.cnt      = cnt_x;
    cmd.value    = item.value;
    cmd.last_idx = (count != '0) ? cnt_x - IDX_W'(1) : NO_IDX;
    cmd.mid_idx  = (cnt_x >= IDX_W'(2)) ? (cnt_x >> 1) : NO_IDX;
    cmd.rd_idx   = rd_ok ? IDX_W'(rd_pos) - IDX_W'(1) : NO_IDX;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      bol_cell #(.INDEX(i)) u_cell (
        .clk  (clk),
        .cmd  (cmd),
        .left (item.value),
        .val  (cell_val[i]),
        .tap  (cell_tap[i])
      );
    end else begin : g_body
      bol_cell #(.INDEX(i)) u_cell (
        .clk  (clk),
        .cmd  (cmd),
        .left (cell_val[i-1]),
        .val  (cell_val[i]),
        .tap  (cell_tap[i])
      );
    end
  end

  always_comb begin
    last_or = '0;
    mid_or  = '0;
    rd_or   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      last_or = last_or | cell_tap[i].last;
      mid_or  = mid_or  | cell_tap[i].mid;
      rd_or   = rd_or   | cell_tap[i].rd;
    end
  end

  always_comb begin
    res_next.status       = status;
    res_next.entry_count  = 5'(count);
    res_next.first_value  = (count != '0) ? cell_val[0] : '0;
    res_next.last_value   = last_or;
    res_next.middle_value = mid_or;
    res_next.middle_valid = (cnt_x >= IDX_W'(2));
    res_next.read_value   = rd_or;
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) state_next = S_GATHER;
      end
      S_GATHER: begin
        if (!result_valid || result_ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.ins) count <= count + CW'(1);
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      rd_ok  <= rd_ok_next;
      rd_pos <= item.position;
    end
    if (load) result <= res_next;
  end

endmodule
`default_nettype wire

/* sv/bol_cell.sv */
// One list slot: takes the new value or its left neighbour's, and taps itself out on match.
`default_nettype none
module bol_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                      clk,
  input  wire bol_pkg::cell_cmd_t        cmd,
  input  wire logic [bol_pkg::VAL_W-1:0] left,
  output logic [bol_pkg::VAL_W-1:0]      val,
  output bol_pkg::cell_tap_t             tap
);
  import bol_pkg::*;

  localparam logic [IDX_W-1:0] MY = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.ins && MY == cmd.idx) begin
      val <= cmd.value;
    end else if (cmd.ins && MY > cmd.idx && MY <= cmd.cnt) begin
      val <= left;
    end
  end

  always_comb begin
    tap.last = (MY == cmd.last_idx) ? val : '0;
    tap.mid  = (MY == cmd.mid_idx)  ? val : '0;
    tap.rd   = (MY == cmd.rd_idx)   ? val : '0;
  end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for the bounded ordered list: directed table, then random beats checked against a list model.
module tb;
  import bol_pkg::*;

  localparam int LIST_DEPTH  = DEFAULT_MAX_ENTRIES;
  localparam int N_RANDOM    = 1120;
  localparam int N_CALM      = 150;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    item_t   it;
    int      reps;
    bit      typed;
    result_t exp;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  stim_row_t          stim_rows[$];
  logic signed [31:0] list_shadow[$];
  result_t            awaited_results[$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int n_ok         = 0;
  int n_bad        = 0;
  int n_full       = 0;
  int n_hits       = 0;
  bit calm         = 1'b0;
  bit hold_active  = 1'b0;
  bit hold_done    = 1'b0;
  int burst_pct[4] = '{0, 20, 50, 10};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_ordered_list u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  function automatic result_t make_result(status_t st, int cnt, logic signed [31:0] first,
                                          logic signed [31:0] last, logic signed [31:0] mid,
                                          bit mv, logic signed [31:0] rd);
    result_t r;
    r.status       = st;
    r.entry_count  = 5'(cnt);
    r.first_value  = first;
    r.last_value   = last;
    r.middle_value = mid;
    r.middle_valid = mv;
    r.read_value   = rd;
    return r;
  endfunction

  function automatic void add_row(action_t a, logic signed [31:0] v, logic [7:0] p,
                                  int reps = 1, bit typed = 1'b0, result_t exp = '0);
    stim_row_t r;
    r.it.action   = a;
    r.it.value    = v;
    r.it.position = p;
    r.reps        = reps;
    r.typed       = typed;
    r.exp         = exp;
    stim_rows.push_back(r);
  endfunction

  // Applies one beat to the shadow list and returns the result it should give.
  function automatic result_t apply_to_list(item_t it);
    result_t r;
    int      cnt;
    int      p;
    int      n;
    cnt = list_shadow.size();
    p   = it.position;
    r   = '0;
    r.status = ST_OK;
    if (action_t'(it.action) == ACT_READ) begin
      if (p >= 1 && p <= cnt) r.read_value = list_shadow[p-1];
      else r.status = ST_BAD_POS;
    end else if (action_t'(it.action) == ACT_AT && (p < 1 || p > cnt + 1)) begin
      r.status = ST_BAD_POS;
    end else if (cnt >= LIST_DEPTH) begin
      r.status = ST_FULL;
    end else begin
      case (action_t'(it.action))
        ACT_FRONT: list_shadow.push_front(it.value);
        ACT_BACK:  list_shadow.push_back(it.value);
        default:   list_shadow.insert(p - 1, it.value);
      endcase
    end
    n = list_shadow.size();
    r.entry_count = 5'(n);
    if (n > 0) begin
      r.first_value = list_shadow[0];
      r.last_value  = list_shadow[n-1];
    end
    if (n >= 2) begin
      r.middle_value = list_shadow[n/2];
      r.middle_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, exp, got);
    end
  endfunction

  task automatic maybe_pause();
    int pct;
    pct = burst_pct[(items_sent / 50) % 4];
    if (!calm && !hold_active && $urandom_range(0, 99) < pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic send_item(item_t it, bit typed = 1'b0, result_t exp = '0);
    result_t predicted;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predicted = apply_to_list(it);
    awaited_results.push_back(typed ? exp : predicted);
    case (status_t'(predicted.status))
      ST_OK:      n_ok++;
      ST_BAD_POS: n_bad++;
      default:    n_full++;
    endcase
    if (action_t'(it.action) == ACT_READ && status_t'(predicted.status) == ST_OK) n_hits++;
    items_sent++;
    @(negedge clk);
  endtask

  initial begin
    stim_row_t r;
    item_t     it;
    int        k;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;

    // empty list
    add_row(ACT_READ, 0, 1, 1, 1, make_result(ST_BAD_POS, 0, 0, 0, 0, 0, 0));
    add_row(ACT_READ, 0, 0, 1, 1, make_result(ST_BAD_POS, 0, 0, 0, 0, 0, 0));
    add_row(ACT_AT, 32'sd9, 0, 1, 1, make_result(ST_BAD_POS, 0, 0, 0, 0, 0, 0));
    add_row(ACT_AT, 32'sd9, 2, 1, 1, make_result(ST_BAD_POS, 0, 0, 0, 0, 0, 0));
    add_row(ACT_BACK, VAL_MAX, 0, 1, 1, make_result(ST_OK, 1, VAL_MAX, VAL_MAX, 0, 0, 0));
    add_row(ACT_FRONT, VAL_MIN, 8'hFF, 1, 1,
            make_result(ST_OK, 2, VAL_MIN, VAL_MAX, VAL_MAX, 1, 0));
    add_row(ACT_READ, 0, 2, 1, 1, make_result(ST_OK, 2, VAL_MIN, VAL_MAX, VAL_MAX, 1, VAL_MAX));
    add_row(ACT_READ, 0, 3, 1, 1, make_result(ST_BAD_POS, 2, VAL_MIN, VAL_MAX, VAL_MAX, 1, 0));
    // positional inserts and reads
    add_row(ACT_AT, -32'sd1, 3);
    add_row(ACT_AT, 32'sd0, 1);
    add_row(ACT_AT, 32'sh5A5A_5A5A, 2);
    add_row(ACT_AT, 32'sd3, 7);
    add_row(ACT_READ, 0, 5);
    add_row(ACT_READ, 0, 8'hFF);
    add_row(ACT_AT, 32'sd3, 8'hFF);
    // fill up at random positions
    add_row(ACT_AT, 0, 1, LIST_DEPTH - 5);
    // full list
    add_row(ACT_FRONT, 32'sd1, 0);
    add_row(ACT_BACK, 32'sd1, 0);
    add_row(ACT_AT, 32'sd1, 8'(LIST_DEPTH + 1));
    add_row(ACT_AT, 32'sd1, 8'(LIST_DEPTH + 2));
    add_row(ACT_AT, 32'sd1, 0);
    add_row(ACT_READ, 0, 8'(LIST_DEPTH));
    add_row(ACT_READ, 0, 8'(LIST_DEPTH + 1));
    add_row(ACT_READ, 0, 8'(LIST_DEPTH / 2));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      for (k = 0; k < r.reps; k++) begin
        it = r.it;
        if (r.reps > 1) begin
          it.value = $urandom;
          if (action_t'(it.action) == ACT_AT)
            it.position = 8'($urandom_range(1, list_shadow.size() + 1));
        end
        maybe_pause();
        send_item(it, r.typed, r.exp);
      end
    end

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - N_CALM) calm = 1'b1;
      it.action   = 2'($urandom_range(0, 3));
      it.value    = $urandom;
      it.position = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, LIST_DEPTH + 1))
                                               : 8'($urandom_range(0, 255));
      maybe_pause();
      send_item(it);
    end
    item_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d beats: %0d ok, %0d bad position, %0d list full; %0d reads hit entries.",
             items_sent, n_ok, n_bad, n_full, n_hits);
    $display("Checked %0d result beats at depth %0d, with a %0d-cycle output hold.",
             results_seen, LIST_DEPTH, HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side back-pressure; one long hold to fill the block.
  initial begin
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= 100) begin
        hold_active = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < burst_pct[(results_seen / 40) % 4]) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got %0h", $time, result);
      end else begin
        check_field("status", awaited_results[0].status, result.status);
        check_field("entry_count", awaited_results[0].entry_count, result.entry_count);
        check_field("first_value", awaited_results[0].first_value, result.first_value);
        check_field("last_value", awaited_results[0].last_value, result.last_value);
        check_field("middle_value", awaited_results[0].middle_value, result.middle_value);
        check_field("middle_valid", awaited_results[0].middle_valid, result.middle_valid);
        check_field("read_value", awaited_results[0].read_value, result.read_value);
        void'(awaited_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
